// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock edge, off while reset is held.
`define QSA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on the rising clock edge, in reset as well.
`define QSA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/qsa_pkg.sv -----
// ----------------------------------------------------------------------------
// qsa_pkg
// Types and constants of the quadrature setpoint adjuster.
// ----------------------------------------------------------------------------
package qsa_pkg;

    localparam int unsigned LIMIT_W = 7;
    localparam int unsigned REQ_W   = 2;
    localparam int unsigned PHASE_W = 2;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned ADDR_W  = 3;

    typedef logic [LIMIT_W-1:0] limit_t;
    typedef logic [PHASE_W-1:0] phase_t;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_INIT   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ENC    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_BUTTON = 2'd2;

    // Register index (paddr bit 2)
    localparam logic REG_MIN = 1'b0;
    localparam logic REG_MAX = 1'b1;

    // Reset values
    localparam limit_t MIN_LIMIT_RST = 7'd40;
    localparam limit_t MAX_LIMIT_RST = 7'd100;
    localparam limit_t UPPER_RST     = 7'd80;
    localparam limit_t LOWER_RST     = 7'd60;
    localparam phase_t PHASE_RST     = 2'd0;

    // Edit selection
    localparam logic EDIT_HIGH = 1'b0;
    localparam logic EDIT_LOW  = 1'b1;

    // Decoded encoder step
    typedef struct packed {
        phase_t next_phase;
        logic   inc;
        logic   dec;
    } step_t;

endpackage

// ----- src/quadrature_setpoint_adjuster_top.sv -----
// ----------------------------------------------------------------------------
// quadrature_setpoint_adjuster_top
// Quadrature encoder driven editor of a high and a low limit, with
// configurable clamp range over an APB-style register port.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    req_type, pin_a, pin_b, buttons
// m_        out        m_valid/m_ready    high/low limit, editing_low, moved
// apb       in         psel/penable       min_limit @0x0, max_limit @0x4
//
// One transaction per cycle sustained while the result is not stalled; the state
// update runs between the input register and the result register, so m_valid
// rises when the held transaction moves from the input to the result register.
// A stalled result keeps the result register full; the input register still
// takes one more transaction, then s_ready drops until m_ready returns.
// Reset (aresetn low, synchronous) empties both stages and loads the limits.
// ----------------------------------------------------------------------------
module quadrature_setpoint_adjuster_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [qsa_pkg::REQ_W-1:0]     s_req_type,
    input  logic                          s_pin_a,
    input  logic                          s_pin_b,
    input  logic                          s_button_high_n,
    input  logic                          s_button_low_n,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [qsa_pkg::LIMIT_W-1:0]   m_high_limit,
    output logic [qsa_pkg::LIMIT_W-1:0]   m_low_limit,
    output logic                          m_editing_low,
    output logic                          m_moved,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [qsa_pkg::ADDR_W-1:0]    paddr,
    input  logic [qsa_pkg::DATA_W-1:0]    pwdata,
    output logic [qsa_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    // configuration
    qsa_pkg::limit_t min_limit_reg;
    qsa_pkg::limit_t max_limit_reg;
    logic            cfg_wr;

    // input stage
    logic                       in_valid_reg;
    logic [qsa_pkg::REQ_W-1:0]  req_reg;
    logic                       pin_a_reg;
    logic                       pin_b_reg;
    logic                       btn_high_n_reg;
    logic                       btn_low_n_reg;

    // state
    qsa_pkg::phase_t phase_reg;
    qsa_pkg::phase_t phase_next;
    qsa_pkg::limit_t upper_reg;
    qsa_pkg::limit_t upper_next;
    qsa_pkg::limit_t lower_reg;
    qsa_pkg::limit_t lower_next;
    logic            edit_reg;
    logic            edit_next;
    logic            moved_next;

    // result stage
    logic            out_valid_reg;
    qsa_pkg::limit_t out_high_reg;
    qsa_pkg::limit_t out_low_reg;
    logic            out_edit_reg;
    logic            out_moved_reg;

    logic            advance;
    qsa_pkg::step_t  step;
    qsa_pkg::limit_t upper_clamped;
    qsa_pkg::limit_t lower_clamped;

    // Register port: always ready, word index on paddr bit 2
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_comb begin
        prdata = '0;
        prdata[qsa_pkg::LIMIT_W-1:0] = (paddr[2] == qsa_pkg::REG_MAX) ? max_limit_reg
                                                                       : min_limit_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_limit_reg <= qsa_pkg::MIN_LIMIT_RST;
            max_limit_reg <= qsa_pkg::MAX_LIMIT_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == qsa_pkg::REG_MAX) begin
                max_limit_reg <= pwdata[qsa_pkg::LIMIT_W-1:0];
            end else begin
                min_limit_reg <= pwdata[qsa_pkg::LIMIT_W-1:0];
            end
        end
    end

    // Process the held transaction when the result slot is free or draining
    assign advance = in_valid_reg & (~out_valid_reg | m_ready);
    assign s_ready = ~in_valid_reg | advance;

    // Capture input transactions
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg        <= s_req_type;
            pin_a_reg      <= s_pin_a;
            pin_b_reg      <= s_pin_b;
            btn_high_n_reg <= s_button_high_n;
            btn_low_n_reg  <= s_button_low_n;
        end
    end

    qsa_step u_step (
        .phase (phase_reg),
        .pin_a (pin_a_reg),
        .pin_b (pin_b_reg),
        .step  (step)
    );

    qsa_clamp u_clamp (
        .edit_sel  (edit_reg),
        .step      (step),
        .upper     (upper_reg),
        .lower     (lower_reg),
        .min_limit (min_limit_reg),
        .max_limit (max_limit_reg),
        .upper_new (upper_clamped),
        .lower_new (lower_clamped)
    );

    // Next state per request type; unused code leaves everything alone
    always_comb begin
        phase_next = phase_reg;
        upper_next = upper_reg;
        lower_next = lower_reg;
        edit_next  = edit_reg;
        moved_next = 1'b0;
        unique case (req_reg)
            qsa_pkg::REQ_INIT: begin
                phase_next = {pin_b_reg, pin_a_reg};
            end
            qsa_pkg::REQ_ENC: begin
                phase_next = step.next_phase;
                upper_next = upper_clamped;
                lower_next = lower_clamped;
                moved_next = step.inc | step.dec;
            end
            qsa_pkg::REQ_BUTTON: begin
                if (!btn_high_n_reg) begin
                    edit_next = qsa_pkg::EDIT_HIGH;
                end else if (!btn_low_n_reg) begin
                    edit_next = qsa_pkg::EDIT_LOW;
                end
            end
            default: begin
                phase_next = phase_reg;
            end
        endcase
    end

    // Advance state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= qsa_pkg::PHASE_RST;
            upper_reg <= qsa_pkg::UPPER_RST;
            lower_reg <= qsa_pkg::LOWER_RST;
            edit_reg  <= qsa_pkg::EDIT_HIGH;
        end else if (advance) begin
            phase_reg <= phase_next;
            upper_reg <= upper_next;
            lower_reg <= lower_next;
            edit_reg  <= edit_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_high_reg  <= upper_next;
            out_low_reg   <= lower_next;
            out_edit_reg  <= edit_next;
            out_moved_reg <= moved_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_high_limit  = out_high_reg;
    assign m_low_limit   = out_low_reg;
    assign m_editing_low = out_edit_reg;
    assign m_moved       = out_moved_reg;

endmodule

// ----- src/qsa_step.sv -----
// ----------------------------------------------------------------------------
// qsa_step
// Quadrature phase decoder: next phase and step direction from the pins.
// ----------------------------------------------------------------------------
module qsa_step (
    input  qsa_pkg::phase_t phase,
    input  logic            pin_a,
    input  logic            pin_b,
    output qsa_pkg::step_t  step
);

    // Walk the four-phase cycle; hold the phase when no transition shows
    always_comb begin
        step.next_phase = phase;
        step.inc        = 1'b0;
        step.dec        = 1'b0;
        unique case (phase)
            2'd0: begin
                if (pin_a) begin
                    step.next_phase = 2'd1;
                    step.inc        = 1'b1;
                end else if (pin_b) begin
                    step.next_phase = 2'd2;
                    step.dec        = 1'b1;
                end
            end
            2'd1: begin
                if (!pin_a) begin
                    step.next_phase = 2'd0;
                    step.dec        = 1'b1;
                end else if (pin_b) begin
                    step.next_phase = 2'd3;
                    step.inc        = 1'b1;
                end
            end
            2'd2: begin
                if (pin_a) begin
                    step.next_phase = 2'd3;
                    step.dec        = 1'b1;
                end else if (!pin_b) begin
                    step.next_phase = 2'd0;
                    step.inc        = 1'b1;
                end
            end
            default: begin
                if (!pin_b) begin
                    step.next_phase = 2'd1;
                    step.dec        = 1'b1;
                end else if (!pin_a) begin
                    step.next_phase = 2'd2;
                    step.inc        = 1'b1;
                end
            end
        endcase
    end

endmodule

// ----- src/qsa_clamp.sv -----
// ----------------------------------------------------------------------------
// qsa_clamp
// Adds the step to the edited limit and clamps it: minimum first, then
// maximum, then the ordering against the other limit.
// ----------------------------------------------------------------------------
module qsa_clamp (
    input  logic             edit_sel,
    input  qsa_pkg::step_t   step,
    input  qsa_pkg::limit_t  upper,
    input  qsa_pkg::limit_t  lower,
    input  qsa_pkg::limit_t  min_limit,
    input  qsa_pkg::limit_t  max_limit,
    output qsa_pkg::limit_t  upper_new,
    output qsa_pkg::limit_t  lower_new
);

    logic signed [8:0]  delta;
    logic signed [8:0]  base;
    logic signed [8:0]  sum;
    logic signed [8:0]  lo_s;
    logic signed [8:0]  hi_s;
    logic signed [8:0]  other_s;
    qsa_pkg::limit_t    clamped;

    // Select the edited limit and form the stepped value
    always_comb begin
        delta   = step.inc ? 9'sd1 : (step.dec ? -9'sd1 : 9'sd0);
        base    = $signed({2'b00, (edit_sel == qsa_pkg::EDIT_LOW) ? lower : upper});
        other_s = $signed({2'b00, (edit_sel == qsa_pkg::EDIT_LOW) ? upper : lower});
        lo_s    = $signed({2'b00, min_limit});
        hi_s    = $signed({2'b00, max_limit});
        sum     = base + delta;
    end

    // Clamp in priority order
    always_comb begin
        priority if (sum < lo_s) begin
            clamped = min_limit;
        end else if (sum > hi_s) begin
            clamped = max_limit;
        end else if ((edit_sel == qsa_pkg::EDIT_LOW) && (sum > other_s)) begin
            clamped = upper;
        end else if ((edit_sel == qsa_pkg::EDIT_HIGH) && (sum < other_s)) begin
            clamped = lower;
        end else begin
            clamped = sum[6:0];
        end
    end

    // Write back only the edited limit
    assign upper_new = (edit_sel == qsa_pkg::EDIT_LOW) ? upper : clamped;
    assign lower_new = (edit_sel == qsa_pkg::EDIT_LOW) ? clamped : lower;

endmodule

// ----- src/qsa_checker.sv -----
// ----------------------------------------------------------------------------
// qsa_checker
// Port-level checks of the quadrature setpoint adjuster, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qsa_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [qsa_pkg::LIMIT_W-1:0] m_high_limit,
    input logic [qsa_pkg::LIMIT_W-1:0] m_low_limit,
    input logic                        m_editing_low,
    input logic                        m_moved
);

    // A stalled result holds its valid and payload
    `QSA_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_high_limit) && $stable(m_low_limit) && $stable(m_editing_low) && $stable(m_moved), "stalled result changed")

    // Reset empties the result stage
    `QSA_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid, "result valid after reset")

    // With no result waiting the block takes input
    `QSA_ASSERT(a_ready_empty, aclk, aresetn, !m_valid |-> s_ready, "not ready while output empty")

    // Every accepted transaction shows a result after the input and result registers
    `QSA_ASSERT(a_latency, aclk, aresetn, s_valid && s_ready |-> ##2 m_valid, "result missing after accept")

endmodule

bind quadrature_setpoint_adjuster_top qsa_checker u_qsa_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_high_limit  (m_high_limit),
    .m_low_limit   (m_low_limit),
    .m_editing_low (m_editing_low),
    .m_moved       (m_moved)
);
